@@ src/ray_triangle_intersection_core_macros.svh @@
// Assertion macros for the ray/triangle intersection core.
// Each macro expects clk_i and rst_ni to be visible in the including module.
`ifndef RAY_TRIANGLE_INTERSECTION_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECTION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rti_pkg.sv @@
// Constants and register codes for the ray/triangle intersection core.
// Has no dependencies.
package rti_pkg;

  localparam int DIR_FRAC  = 14;
  localparam int DIST_BITS = 24;
  localparam int THR_BITS  = 48;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_DIR_X = 2'd0;
  localparam logic [1:0] REG_DIR_Y = 2'd1;
  localparam logic [1:0] REG_DIR_Z = 2'd2;
  localparam logic [1:0] REG_THR   = 2'd3;

  localparam int DIR_X_RST = 0;
  localparam int DIR_Y_RST = 49152;
  localparam int DIR_Z_RST = 0;
  localparam int THR_RST   = 1;

endpackage

@@ src/ray_triangle_intersection_core.sv @@
// Ray/triangle intersection core: pipelined Moller-Trumbore test in exact fixed point.
// Depends on rti_pkg and ray_triangle_intersection_core_macros.svh.
//
// The core takes one word per cycle and gives one result word per input word. Seven
// stages form the cross and dot products and the determinant sign fix-up, one stage
// makes the inside and overflow decisions, a chain of 24 restoring stages produces the
// quotient one bit each, and an output register holds the result. While the output
// register holds a word that is stalled, the whole pipeline freezes and the input is
// stalled. The ray direction and threshold registers are read live, so they should be
// written only when no word is in flight.
`include "ray_triangle_intersection_core_macros.svh"

module ray_triangle_intersection_core #(
  parameter int COORD_BITS = 24,
  parameter int DIR_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_BITS-1:0]          origin_x_i,
  input  logic signed [COORD_BITS-1:0]          origin_y_i,
  input  logic signed [COORD_BITS-1:0]          origin_z_i,
  input  logic signed [COORD_BITS-1:0]          vertex0_x_i,
  input  logic signed [COORD_BITS-1:0]          vertex0_y_i,
  input  logic signed [COORD_BITS-1:0]          vertex0_z_i,
  input  logic signed [COORD_BITS-1:0]          vertex1_x_i,
  input  logic signed [COORD_BITS-1:0]          vertex1_y_i,
  input  logic signed [COORD_BITS-1:0]          vertex1_z_i,
  input  logic signed [COORD_BITS-1:0]          vertex2_x_i,
  input  logic signed [COORD_BITS-1:0]          vertex2_y_i,
  input  logic signed [COORD_BITS-1:0]          vertex2_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  output logic signed [rti_pkg::DIST_BITS-1:0]  distance_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rti_pkg::CFG_AW-1:0]            paddr,
  input  logic [rti_pkg::CFG_DW-1:0]            pwdata,
  output logic [rti_pkg::CFG_DW-1:0]            prdata,
  output logic                                  pready
);
  import rti_pkg::*;

  localparam int EW   = COORD_BITS + 1;
  localparam int PW   = COORD_BITS + DIR_BITS + 2;
  localparam int QW   = 2 * COORD_BITS + 3;
  localparam int DW   = 2 * COORD_BITS + DIR_BITS + 5;
  localparam int TW   = 3 * COORD_BITS + 6;
  localparam int LP   = PW / 2;
  localparam int HP   = PW - LP;
  localparam int LQ   = QW / 2;
  localparam int HQ   = QW - LQ;
  localparam int QB   = DIST_BITS;
  localparam int SH   = QB - DIR_FRAC;
  localparam int NPRE = 7;
  localparam int NV   = NPRE + QB + 1;
  localparam int CMPW = (DW > THR_BITS) ? DW : THR_BITS;
  localparam int MW   = (DW > TW - SH) ? DW : TW - SH;
  localparam int I1[3] = '{1, 2, 0};
  localparam int I2[3] = '{2, 0, 1};

  typedef struct packed {
    logic          miss;
    logic          neg;
    logic          ovf;
    logic [DW-1:0] dabs;
    logic [DW-1:0] rem;
    logic [QB-1:0] nlow;
    logic [QB-1:0] quo;
  } div_stage_t;

  // Configuration registers.
  logic [DIR_BITS-1:0] dir_x_q, dir_y_q, dir_z_q;
  logic [THR_BITS-1:0] thr_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q <= DIR_BITS'(DIR_X_RST);
      dir_y_q <= DIR_BITS'(DIR_Y_RST);
      dir_z_q <= DIR_BITS'(DIR_Z_RST);
      thr_q   <= THR_BITS'(THR_RST);
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_DIR_X: dir_x_q <= pwdata[DIR_BITS-1:0];
        REG_DIR_Y: dir_y_q <= pwdata[DIR_BITS-1:0];
        REG_DIR_Z: dir_z_q <= pwdata[DIR_BITS-1:0];
        REG_THR:   thr_q   <= pwdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_DIR_X: prdata = CFG_DW'(dir_x_q);
      REG_DIR_Y: prdata = CFG_DW'(dir_y_q);
      REG_DIR_Z: prdata = CFG_DW'(dir_z_q);
      REG_THR:   prdata = CFG_DW'(thr_q);
      default:   prdata = '0;
    endcase
  end

  // Pipeline control.
  logic          en;
  logic [NV-1:0] vld_q;
  logic          out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NV-2:0], in_valid_i};
      out_valid_q <= vld_q[NV-1];
    end
  end

  logic signed [COORD_BITS-1:0] org [3];
  logic signed [COORD_BITS-1:0] v0 [3];
  logic signed [COORD_BITS-1:0] v1 [3];
  logic signed [COORD_BITS-1:0] v2 [3];
  logic signed [DIR_BITS-1:0]   dir_s [3];

  assign org   = '{origin_x_i, origin_y_i, origin_z_i};
  assign v0    = '{vertex0_x_i, vertex0_y_i, vertex0_z_i};
  assign v1    = '{vertex1_x_i, vertex1_y_i, vertex1_z_i};
  assign v2    = '{vertex2_x_i, vertex2_y_i, vertex2_z_i};
  assign dir_s = '{$signed(dir_x_q), $signed(dir_y_q), $signed(dir_z_q)};

  // Stage registers.
  logic signed [EW-1:0]            e1_1q [3], e2_1q [3], tv_1q [3];
  logic signed [EW-1:0]            e1_2q [3], e2_2q [3], tv_2q [3];
  logic signed [EW-1:0]            e1_3q [3], e2_3q [3], tv_3q [3];
  logic signed [DIR_BITS+EW-1:0]   pa_q [3], pb_q [3];
  logic signed [2*EW-1:0]          qa_q [3], qb_q [3];
  logic signed [PW-1:0]            p_q [3];
  logic signed [QW-1:0]            qv_q [3];
  logic signed [EW+HP-1:0]         dth_q [3], uth_q [3];
  logic signed [EW+LP:0]           dtl_q [3], utl_q [3];
  logic signed [DIR_BITS+HQ-1:0]   vth_q [3];
  logic signed [DIR_BITS+LQ:0]     vtl_q [3];
  logic signed [EW+HQ-1:0]         tth_q [3];
  logic signed [EW+LQ:0]           ttl_q [3];
  logic signed [DW-1:0]            dt_q [3], ut_q [3], vt_q [3];
  logic signed [TW-1:0]            tt_q [3];
  logic signed [DW-1:0]            det_q, un_q, vn_q;
  logic signed [TW-1:0]            tn_q;
  logic [DW-1:0]                   dabs_q;
  logic signed [DW:0]              un7_q, vn7_q;
  logic [TW-1:0]                   tabs_q;
  logic                            neg7_q;
  div_stage_t                      div_q [QB+1];
  div_stage_t                      div_d [QB+1];
  logic                            out_hit_q;
  logic signed [QB-1:0]            out_dist_q;

  logic                            det_neg;
  logic signed [DW+1:0]            dabs_s, un_w, sum_w;
  logic                            miss8, ovf8;
  logic [DW:0]                     dv_t [QB];
  logic [QB-1:0]                   mag;
  logic [QB-1:0]                   half;
  logic                            res_hit;
  logic signed [QB-1:0]            res_dist;

  assign det_neg = det_q[DW-1];
  assign dabs_s  = $signed({2'b00, dabs_q});
  assign un_w    = (DW+2)'(un7_q);
  assign sum_w   = (DW+2)'(un7_q) + (DW+2)'(vn7_q);
  assign miss8   = (dabs_q == '0) || (CMPW'(dabs_q) < CMPW'(thr_q)) || un7_q[DW]
                   || vn7_q[DW] || (un_w > dabs_s) || (sum_w > dabs_s);
  assign ovf8    = MW'(tabs_q[TW-1:SH]) >= MW'(dabs_q);

  always_comb begin
    div_d[0].miss = miss8;
    div_d[0].neg  = neg7_q;
    div_d[0].ovf  = ovf8;
    div_d[0].dabs = dabs_q;
    div_d[0].rem  = DW'(tabs_q[TW-1:SH]);
    div_d[0].nlow = {tabs_q[SH-1:0], {DIR_FRAC{1'b0}}};
    div_d[0].quo  = '0;
    for (int j = 0; j < QB; j++) begin
      dv_t[j]          = {div_q[j].rem, div_q[j].nlow[QB-1]};
      div_d[j+1]       = div_q[j];
      div_d[j+1].nlow  = {div_q[j].nlow[QB-2:0], 1'b0};
      if (dv_t[j] >= {1'b0, div_q[j].dabs}) begin
        div_d[j+1].rem = DW'(dv_t[j] - {1'b0, div_q[j].dabs});
        div_d[j+1].quo = {div_q[j].quo[QB-2:0], 1'b1};
      end else begin
        div_d[j+1].rem = DW'(dv_t[j]);
        div_d[j+1].quo = {div_q[j].quo[QB-2:0], 1'b0};
      end
    end
  end

  assign half = QB'(1) << (QB - 1);

  always_comb begin
    if (div_q[QB].neg) begin
      mag      = (div_q[QB].ovf || div_q[QB].quo > half) ? half : div_q[QB].quo;
      res_dist = $signed(-mag);
    end else begin
      mag      = (div_q[QB].ovf || div_q[QB].quo > half - 1'b1) ? half - 1'b1 : div_q[QB].quo;
      res_dist = $signed(mag);
    end
    res_hit = !div_q[QB].miss;
    if (div_q[QB].miss) begin
      res_dist = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_1q[k] <= EW'(v1[k]) - EW'(v0[k]);
        e2_1q[k] <= EW'(v2[k]) - EW'(v0[k]);
        tv_1q[k] <= EW'(org[k]) - EW'(v0[k]);

        pa_q[k]  <= dir_s[I1[k]] * e2_1q[I2[k]];
        pb_q[k]  <= dir_s[I2[k]] * e2_1q[I1[k]];
        qa_q[k]  <= tv_1q[I1[k]] * e1_1q[I2[k]];
        qb_q[k]  <= tv_1q[I2[k]] * e1_1q[I1[k]];
        e1_2q[k] <= e1_1q[k];
        e2_2q[k] <= e2_1q[k];
        tv_2q[k] <= tv_1q[k];

        p_q[k]   <= PW'(pa_q[k]) - PW'(pb_q[k]);
        qv_q[k]  <= QW'(qa_q[k]) - QW'(qb_q[k]);
        e1_3q[k] <= e1_2q[k];
        e2_3q[k] <= e2_2q[k];
        tv_3q[k] <= tv_2q[k];

        dth_q[k] <= e1_3q[k] * $signed(p_q[k][PW-1:LP]);
        dtl_q[k] <= e1_3q[k] * $signed({1'b0, p_q[k][LP-1:0]});
        uth_q[k] <= tv_3q[k] * $signed(p_q[k][PW-1:LP]);
        utl_q[k] <= tv_3q[k] * $signed({1'b0, p_q[k][LP-1:0]});
        vth_q[k] <= dir_s[k] * $signed(qv_q[k][QW-1:LQ]);
        vtl_q[k] <= dir_s[k] * $signed({1'b0, qv_q[k][LQ-1:0]});
        tth_q[k] <= e2_3q[k] * $signed(qv_q[k][QW-1:LQ]);
        ttl_q[k] <= e2_3q[k] * $signed({1'b0, qv_q[k][LQ-1:0]});

        dt_q[k]  <= (DW'(dth_q[k]) <<< LP) + DW'(dtl_q[k]);
        ut_q[k]  <= (DW'(uth_q[k]) <<< LP) + DW'(utl_q[k]);
        vt_q[k]  <= (DW'(vth_q[k]) <<< LQ) + DW'(vtl_q[k]);
        tt_q[k]  <= (TW'(tth_q[k]) <<< LQ) + TW'(ttl_q[k]);
      end

      det_q  <= dt_q[0] + dt_q[1] + dt_q[2];
      un_q   <= ut_q[0] + ut_q[1] + ut_q[2];
      vn_q   <= vt_q[0] + vt_q[1] + vt_q[2];
      tn_q   <= tt_q[0] + tt_q[1] + tt_q[2];

      dabs_q <= det_neg ? DW'(-det_q) : DW'(det_q);
      un7_q  <= det_neg ? -(DW+1)'(un_q) : (DW+1)'(un_q);
      vn7_q  <= det_neg ? -(DW+1)'(vn_q) : (DW+1)'(vn_q);
      tabs_q <= tn_q[TW-1] ? TW'(-tn_q) : TW'(tn_q);
      neg7_q <= tn_q[TW-1] ^ det_neg;

      for (int j = 0; j <= QB; j++) begin
        div_q[j] <= div_d[j];
      end

      out_hit_q  <= res_hit;
      out_dist_q <= res_dist;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign distance_o  = out_dist_q;

  `RTI_ASSERT_IMP(a_stall_back, out_valid_q && out_stall_i, in_stall_o, "input not stalled")
  `RTI_ASSERT_IMP(a_miss_zero, out_valid_q && !out_hit_q, out_dist_q == '0, "miss with distance")
  `RTI_ASSERT_NXT(a_drain, en && vld_q[NV-1], out_valid_q, "last stage word lost")
  `RTI_ASSERT_NXT(a_freeze, out_valid_q && out_stall_i, $stable(vld_q), "pipeline moved in stall")

endmodule
